// ----- rtl/itrd_pkg.sv -----
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, sizes and digit encoding for the radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

	localparam int VALUE_BITS = 64;
	localparam int MAX_DIGITS = 64;

	localparam int BIT_W  = $clog2(VALUE_BITS);
	localparam int ADDR_W = $clog2(MAX_DIGITS);

	localparam logic [5:0] RADIX_MIN   = 6'd2;
	localparam logic [5:0] RADIX_MAX   = 6'd36;
	localparam logic [5:0] RADIX_RESET = 6'd16;

	localparam logic [6:0] CHAR_ZERO   = 7'd48;
	localparam logic [6:0] CHAR_LETTER = 7'd55;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_en;
		logic st_en;
		logic rd_en;
	} ctrl_t;

	function automatic logic [6:0] digit_to_char(input logic [5:0] d);
		logic [6:0] c;
		if (d < 6'd10) begin
			c = CHAR_ZERO + {1'b0, d};
		end else if (d < 6'd36) begin
			c = CHAR_LETTER + {1'b0, d};
		end else begin
			c = CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

// ----- rtl/integer_to_radix_digits_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts an unsigned value into ASCII digits in a radix of 2 to 36,
// most significant digit first, with the final digit flagged.
// ----------------------------------------------------------------------------
// the bit-serial divider produces the digits one at a time, then the digits are emitted;
// the first digit appears in the cycle after emission starts
// a new value is accepted only when busy is low, after the last digit is out; all digits
// come from the shared one-bit-per-cycle restoring divider
// reset: state machine idle, radix 16, digit store contents undefined
// results are strobed for one cycle each; the receiver cannot stall
module integer_to_radix_digits_core
	import itrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	input  logic        radix_we,
	input  logic [5:0]  radix_wdata,
	output logic        digit_valid,
	output logic [6:0]  digit_char,
	output logic        last_digit
);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic [5:0]            radix_q;
	logic [VALUE_BITS-1:0] quot_q;
	logic [5:0]            rem_q;
	logic [BIT_W-1:0]      bit_cnt_q;
	logic [ADDR_W-1:0]     dcnt_q;
	logic [ADDR_W-1:0]     rd_ptr_q;

	logic [5:0] digit_mem [MAX_DIGITS];
	logic [5:0] rd_data_s1;
	logic       rd_vld_s1;
	logic       last_s1;

	logic [6:0] trial;
	logic       ge;
	logic [5:0] rem_d;
	logic       bits_done;
	logic       more_digits;
	logic       emit_done;
	logic       accept;

	assign accept      = start && !busy;
	assign trial       = {rem_q, quot_q[VALUE_BITS-1]};
	assign ge          = trial >= {1'b0, radix_q};
	assign rem_d       = ge ? 6'(trial - {1'b0, radix_q}) : trial[5:0];
	assign bits_done   = bit_cnt_q == BIT_W'(VALUE_BITS - 1);
	assign more_digits = (quot_q != '0) && (dcnt_q != ADDR_W'(MAX_DIGITS - 1));
	assign emit_done   = rd_ptr_q == '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_DIV;
			ST_DIV:   if (bits_done) state_d = ST_STORE;
			ST_STORE: state_d = more_digits ? ST_DIV : ST_EMIT;
			ST_EMIT:  if (emit_done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:  ctrl.load   = accept;
			ST_DIV:   ctrl.div_en = 1'b1;
			ST_STORE: ctrl.st_en  = 1'b1;
			ST_EMIT:  ctrl.rd_en  = 1'b1;
			default:  ctrl = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE) || rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			radix_q   <= RADIX_RESET;
			quot_q    <= '0;
			rem_q     <= '0;
			bit_cnt_q <= '0;
			dcnt_q    <= '0;
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ctrl.rd_en;
			if (radix_we) begin
				if (radix_wdata < RADIX_MIN) begin
					radix_q <= RADIX_MIN;
				end else if (radix_wdata > RADIX_MAX) begin
					radix_q <= RADIX_MAX;
				end else begin
					radix_q <= radix_wdata;
				end
			end
			if (ctrl.load) begin
				quot_q    <= value[VALUE_BITS-1:0];
				rem_q     <= '0;
				bit_cnt_q <= '0;
				dcnt_q    <= '0;
			end
			if (ctrl.div_en) begin
				quot_q    <= {quot_q[VALUE_BITS-2:0], ge};
				rem_q     <= rem_d;
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (ctrl.st_en) begin
				rem_q     <= '0;
				bit_cnt_q <= '0;
				if (more_digits) begin
					dcnt_q <= dcnt_q + 1'b1;
				end
				rd_ptr_q <= dcnt_q;
			end
			if (ctrl.rd_en) begin
				last_s1  <= emit_done;
				rd_ptr_q <= rd_ptr_q - 1'b1;
			end
		end
	end

	// digit store
	always_ff @(posedge clk) begin
		if (ctrl.st_en) begin
			digit_mem[dcnt_q] <= rem_q;
		end
		if (ctrl.rd_en) begin
			rd_data_s1 <= digit_mem[rd_ptr_q];
		end
	end

	assign digit_valid = rd_vld_s1;
	assign digit_char  = digit_to_char(rd_data_s1);
	assign last_digit  = last_s1;

endmodule
